// File: src/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies.
package sitda_pkg;

  localparam int MAG_W   = 17;  // magnitudes below 100000
  localparam int PLACE_W = 3;   // decimal place index 0..4

  localparam logic [7:0]       CHAR_ZERO  = 8'd48;
  localparam logic [7:0]       CHAR_MINUS = 8'd45;
  localparam logic [31:0]      MAG_LIMIT  = 32'd100000;

  localparam logic [PLACE_W-1:0] PLACE_ONES         = 3'd0;
  localparam logic [PLACE_W-1:0] PLACE_TENS         = 3'd1;
  localparam logic [PLACE_W-1:0] PLACE_HUNDREDS     = 3'd2;
  localparam logic [PLACE_W-1:0] PLACE_THOUSANDS    = 3'd3;
  localparam logic [PLACE_W-1:0] PLACE_TEN_THOUSAND = 3'd4;

  // One classified value waiting for conversion
  typedef struct packed {
    logic                 negative;
    logic                 has_digits;
    logic [PLACE_W-1:0]   top_place;   // place of the leading digit
    logic [MAG_W-1:0]     mag;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } queue_wr_t;

  typedef struct packed {
    logic   empty;
    entry_t head;
  } queue_rd_t;

  // d * 10^place, a constant table of 5 x 10 entries
  function automatic logic [MAG_W-1:0] place_val(input logic [PLACE_W-1:0] place,
                                                 input logic [3:0] d);
    logic [MAG_W-1:0] pow;
    unique case (place)
      PLACE_ONES:         pow = 17'd1;
      PLACE_TENS:         pow = 17'd10;
      PLACE_HUNDREDS:     pow = 17'd100;
      PLACE_THOUSANDS:    pow = 17'd1000;
      PLACE_TEN_THOUSAND: pow = 17'd10000;
      default:            pow = 17'd1;
    endcase
    return MAG_W'(pow * {13'b0, d});
  endfunction

endpackage

// File: src/sitda_in_if.sv
// Input channel: one signed 32-bit value per item.
// No dependencies.
interface sitda_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: src/sitda_out_if.sv
// Output channel: one ASCII character and end-of-run flag per item.
// No dependencies.
interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       run_last;

  modport source (output valid, output text_char, output run_last, input ready);
  modport sink   (input valid, input text_char, input run_last, output ready);
endinterface

// File: src/signed_int_to_decimal_ascii_unit.sv
// The first character of a value passes through the queue slot and then the output register
// before it can be taken, and a busy back end or a stalled output can hold it back longer.
// Throughput: one character per cycle while the output is taken, and a value has 1 to 6
// characters; the output register and the character-per-cycle back end set the pace.
// A positive value of 100000 or more produces no characters and is consumed without a push.
// Reset (rst, synchronous, active high) empties the queue, the back end and the output.
// Depends on sitda_pkg, sitda_in_if, sitda_out_if, sitda_front, sitda_queue, sitda_back.
module signed_int_to_decimal_ascii_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic         clk,
  input logic         rst,
  sitda_in_if.sink    number,
  sitda_out_if.source text
);

  sitda_pkg::queue_wr_t wr;
  sitda_pkg::queue_rd_t rd;
  logic                 full;
  logic                 pop;

  // Front: negate, range check, find leading decimal place. Accepts whenever
  // the queue has room; out-of-range positives are consumed without a push.
  sitda_front u_front (
    .number (number),
    .full   (full),
    .wr     (wr)
  );

  // Queue lets the front keep taking values while the back end is
  // still spelling out an earlier one.
  sitda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .full (full),
    .rd   (rd)
  );

  // Back: minus first for negatives, then, for values in range, one digit per cycle while the
  // output is not stalled, from the leading place down to the ones place; run_last marks the final one.
  sitda_back u_back (
    .clk  (clk),
    .rst  (rst),
    .rd   (rd),
    .pop  (pop),
    .text (text)
  );

endmodule

// File: src/sitda_front.sv
// Front end: accepts values, takes the magnitude and classifies range and digit count.
// Depends on sitda_pkg and sitda_in_if.
module sitda_front (
  sitda_in_if.sink            number,
  input  logic                full,
  output sitda_pkg::queue_wr_t wr
);

  logic        negative;
  logic [31:0] mag_full;
  logic        in_range;
  logic [sitda_pkg::MAG_W-1:0]   mag;
  logic [sitda_pkg::PLACE_W-1:0] top_place;

  always_comb begin
    negative = number.value[31];
    mag_full = negative ? (32'd0 - number.value) : number.value;
    // most negative value negates to itself and falls out of range here too
    in_range = (mag_full < sitda_pkg::MAG_LIMIT);
    mag      = mag_full[sitda_pkg::MAG_W-1:0];
    if (mag >= 17'd10000)     top_place = sitda_pkg::PLACE_TEN_THOUSAND;
    else if (mag >= 17'd1000) top_place = sitda_pkg::PLACE_THOUSANDS;
    else if (mag >= 17'd100)  top_place = sitda_pkg::PLACE_HUNDREDS;
    else if (mag >= 17'd10)   top_place = sitda_pkg::PLACE_TENS;
    else                      top_place = sitda_pkg::PLACE_ONES;
  end

  assign number.ready = !full;

  // out-of-range positives produce nothing and are dropped here
  assign wr.push                = number.valid && !full && (negative || in_range);
  assign wr.entry.negative      = negative;
  assign wr.entry.has_digits    = in_range;
  assign wr.entry.top_place     = top_place;
  assign wr.entry.mag           = mag;

endmodule

// File: src/sitda_queue.sv
// Small register queue between front and back end.
// Depends on sitda_pkg.
module sitda_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sitda_pkg::queue_wr_t wr,
  input  logic                 pop,
  output logic                 full,
  output sitda_pkg::queue_rd_t rd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sitda_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign rd.empty = (count == '0);
  assign rd.head  = slots[rd_ptr];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && !rd.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr.entry;
    end
  end

endmodule

// File: src/sitda_back.sv
// Back end: walks the decimal places of each queued value and emits characters.
// Depends on sitda_pkg and sitda_out_if.
module sitda_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sitda_pkg::queue_rd_t rd,
  output logic                 pop,
  sitda_out_if.source          text
);

  logic                          busy;
  logic [sitda_pkg::MAG_W-1:0]   rest;
  logic [sitda_pkg::PLACE_W-1:0] place;
  logic                          out_valid;
  logic [7:0]                    out_char;
  logic                          out_last;

  logic                          advance;
  logic [sitda_pkg::MAG_W-1:0]   cur_rest;
  logic [sitda_pkg::PLACE_W-1:0] cur_place;
  logic [sitda_pkg::MAG_W-1:0]   thr;
  logic [sitda_pkg::MAG_W-1:0]   sub;
  logic [3:0]                    digit;
  logic [sitda_pkg::MAG_W-1:0]   rem;
  logic [7:0]                    digit_char;

  assign advance = !out_valid || text.ready;
  assign pop     = advance && !busy && !rd.empty;

  // digit = number of multiples d*10^place not above the remainder
  always_comb begin
    cur_rest  = busy ? rest  : rd.head.mag;
    cur_place = busy ? place : rd.head.top_place;
    digit = 4'd0;
    sub   = '0;
    for (int d = 1; d <= 9; d++) begin
      thr = sitda_pkg::place_val(cur_place, 4'(d));
      if (cur_rest >= thr) begin
        digit = 4'(d);
        sub   = thr;
      end
    end
    rem        = cur_rest - sub;
    digit_char = sitda_pkg::CHAR_ZERO + {4'b0, digit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (busy) begin
        out_valid <= 1'b1;
        out_char  <= digit_char;
        out_last  <= (place == sitda_pkg::PLACE_ONES);
        busy      <= (place != sitda_pkg::PLACE_ONES);
        rest      <= rem;
        place     <= place - 3'd1;
      end else if (!rd.empty) begin
        out_valid <= 1'b1;
        if (rd.head.negative) begin
          out_char <= sitda_pkg::CHAR_MINUS;
          out_last <= !rd.head.has_digits;
          busy     <= rd.head.has_digits;
          rest     <= rd.head.mag;
          place    <= rd.head.top_place;
        end else begin
          out_char <= digit_char;
          out_last <= (rd.head.top_place == sitda_pkg::PLACE_ONES);
          busy     <= (rd.head.top_place != sitda_pkg::PLACE_ONES);
          rest     <= rem;
          place    <= rd.head.top_place - 3'd1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign text.valid     = out_valid;
  assign text.text_char = out_char;
  assign text.run_last  = out_last;

endmodule
